### rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg: shared constants and helpers for the pairwise span table
// Field widths, register reset values, result codes and the gap function.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned CAP_W       = 11;
  localparam int unsigned IN_TDATA_W  = 32;
  // held_count, shortest_span, longest_span = 75 bits, padded to 80
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [VALUE_W-1:0] MIN_RESET = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] MAX_RESET = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] GAP_RESET = 32'hFFFF_FFFF;

  // Result status codes.
  localparam logic STATUS_STORED   = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // Two or more held numbers make the spans meaningful.
  localparam logic [COUNT_W-1:0] SPAN_MIN_COUNT = 11'd2;

  // True when a is below b as two's complement numbers.
  function automatic logic signed_less(input logic [VALUE_W-1:0] a,
                                       input logic [VALUE_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Absolute difference of two signed numbers; always fits unsigned 32 bits.
  function automatic logic [VALUE_W-1:0] abs_gap(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
    return signed_less(a, b) ? (b - a) : (a - b);
  endfunction

endpackage

### rtl/pst_ram.sv
// ----------------------------------------------------------------------------
// pst_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/pairwise_span_table_unit.sv
// ----------------------------------------------------------------------------
// pairwise_span_table_unit: bounded store with closest and widest pair report
// Stores signed 32-bit numbers up to a programmable capacity and reports,
// per request, the count, the smallest absolute pairwise difference and
// the difference between the largest and smallest held number.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Ports                      | Payload
//  --------+-----------+----------------------------+---------------------------
//  in_     | slave     | tvalid, tready, tdata[31:0]| new_value
//  out_    | master    | tvalid, tready, tdata[79:0]| held_count, shortest_span,
//          |           | tuser[1:0]                 | longest_span; status, valid
//  cfg_    | write     | wr_en, wr_data[10:0]       | capacity
//
// A rejected request (store at capacity) is answered in the cycle after it is
// accepted. A stored request sweeps every held number through the single
// read port of the value memory, one entry per cycle, then passes through
// the commit state before its result is registered.
// The block takes one request at a time; in_tready is low during the sweep.
// Reset (rst_n low, synchronous) empties the store at once; the memory is
// not cleared, since only entries below the held count are ever read.
// A result waiting on out_tready holds off the next request until it leaves.
// ----------------------------------------------------------------------------
module pairwise_span_table_unit
  import pst_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input requests
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] new_value
  // Results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [10:0] held_count,
                                             // [42:11] shortest_span,
                                             // [74:43] longest_span, rest zero
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] status, [1] span_valid
  // Configuration
  input  logic                   cfg_wr_en,
  input  logic [CAP_W-1:0]       cfg_wr_data // capacity
);

  localparam int unsigned AW = $clog2(DEPTH);
  // Largest count the store can ever reach, bounded by the count width.
  localparam int unsigned LIMIT_MAX = (DEPTH < (2**COUNT_W - 1)) ? DEPTH
                                                                : (2**COUNT_W - 1);
  localparam logic [COUNT_W-1:0] LIMIT_MAX_C = COUNT_W'(LIMIT_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t               state_r,     state_nxt;
  logic [CAP_W-1:0]     cap_r,       cap_nxt;
  logic [COUNT_W-1:0]   count_r,     count_nxt;
  logic [COUNT_W-1:0]   idx_r,       idx_nxt;
  logic [VALUE_W-1:0]   value_r,     value_nxt;
  logic [VALUE_W-1:0]   min_r,       min_nxt;
  logic [VALUE_W-1:0]   max_r,       max_nxt;
  logic [VALUE_W-1:0]   best_r,      best_nxt;
  logic [VALUE_W-1:0]   gap_r,       gap_nxt;
  logic                 rd_vld_r,    rd_vld_nxt;
  logic                 gap_vld_r,   gap_vld_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 status_r,    status_nxt;
  logic                 sv_r,        sv_nxt;
  logic [COUNT_W-1:0]   held_r,      held_nxt;
  logic [VALUE_W-1:0]   short_r,     short_nxt;
  logic [VALUE_W-1:0]   long_r,      long_nxt;

  logic [COUNT_W-1:0]   limit;
  logic                 in_accept;
  logic                 store_full;
  logic                 rd_en;
  logic                 wr_en;
  logic [VALUE_W-1:0]   rd_data;
  logic                 cur_valid;
  logic                 new_valid;

  // Usable capacity never exceeds the memory depth.
  assign limit      = (COUNT_W'(cap_r) < LIMIT_MAX_C) ? COUNT_W'(cap_r) : LIMIT_MAX_C;
  assign store_full = (count_r >= limit);

  // A new request is taken only when idle and the result slot is free or
  // being emptied in this same cycle.
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;

  assign rd_en = (state_r == ST_SCAN) && (idx_r < count_r);
  assign wr_en = (state_r == ST_COMMIT);

  assign cur_valid = (count_r >= SPAN_MIN_COUNT);
  assign new_valid = (count_nxt >= SPAN_MIN_COUNT);

  pst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(count_r)),
    .wr_data (value_r),
    .rd_en   (rd_en),
    .rd_addr (AW'(idx_r)),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cfg_wr_en ? cfg_wr_data : cap_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    value_nxt     = value_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    best_nxt      = best_r;
    gap_nxt       = gap_r;
    rd_vld_nxt    = 1'b0;
    gap_vld_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    sv_nxt        = sv_r;
    held_nxt      = held_r;
    short_nxt     = short_r;
    long_nxt      = long_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          value_nxt = in_tdata[VALUE_W-1:0];
          if (store_full) begin
            // Rejected: report the state as it stands.
            out_valid_nxt = 1'b1;
            status_nxt    = STATUS_REJECTED;
            held_nxt      = count_r;
            sv_nxt        = cur_valid;
            short_nxt     = cur_valid ? best_r : '0;
            long_nxt      = cur_valid ? (max_r - min_r) : '0;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Read one held entry per cycle; the gap unit works on the registered
        // read data and the best-gap compare on the registered gap.
        if (rd_en) begin
          idx_nxt = idx_r + 1'b1;
        end
        rd_vld_nxt  = rd_en;
        gap_vld_nxt = rd_vld_r;
        if (rd_vld_r) begin
          gap_nxt = abs_gap(rd_data, value_r);
        end
        if (gap_vld_r && (gap_r < best_r)) begin
          best_nxt = gap_r;
        end
        if (!rd_en && !rd_vld_r && !gap_vld_r) begin
          state_nxt = ST_COMMIT;
        end
      end

      ST_COMMIT: begin
        count_nxt = count_r + 1'b1;
        if (signed_less(value_r, min_r)) begin
          min_nxt = value_r;
        end
        if (signed_less(max_r, value_r)) begin
          max_nxt = value_r;
        end
        out_valid_nxt = 1'b1;
        status_nxt    = STATUS_STORED;
        held_nxt      = count_nxt;
        sv_nxt        = new_valid;
        short_nxt     = new_valid ? best_r : '0;
        long_nxt      = new_valid ? (max_nxt - min_nxt) : '0;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= '0;
      count_r     <= '0;
      min_r       <= MIN_RESET;
      max_r       <= MAX_RESET;
      best_r      <= GAP_RESET;
      rd_vld_r    <= 1'b0;
      gap_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      best_r      <= best_nxt;
      rd_vld_r    <= rd_vld_nxt;
      gap_vld_r   <= gap_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r    <= idx_nxt;
    value_r  <= value_nxt;
    gap_r    <= gap_nxt;
    status_r <= status_nxt;
    sv_r     <= sv_nxt;
    held_r   <= held_nxt;
    short_r  <= short_nxt;
    long_r   <= long_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - COUNT_W - 2*VALUE_W){1'b0}},
                       long_r, short_r, held_r};
  assign out_tuser  = {sv_r, status_r};

  // The held count never passes the memory depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LIMIT_MAX_C)
    else $error("held count exceeds store depth");

  // A request taken while the store is full is answered next cycle as rejected.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && store_full) |=> (out_valid_r && (status_r == STATUS_REJECTED)))
    else $error("full-store request not answered as rejected");

  // Each commit adds exactly one number.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT) |=> (count_r == $past(count_r) + 1'b1))
    else $error("commit did not advance the held count by one");

  // Once anything is held, the running minimum is not above the maximum.
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> !signed_less(max_r, min_r))
    else $error("running minimum above running maximum");

  // The read and gap pipeline is active only during a sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r || gap_vld_r) |-> (state_r == ST_SCAN))
    else $error("gap pipeline active outside a sweep");

endmodule
